// ===== rtl/core/qrs_pkg.sv =====
// shared constants, types and helpers of the quadratic root solver
package qrs_pkg;

  localparam int FRAC_BITS = 16;
  localparam int COEF_W    = 16;
  localparam int PROD_W    = 2 * COEF_W;
  localparam int DISC_W    = PROD_W + 3;
  localparam int MAG_W     = DISC_W - 1;
  localparam int RAD_W     = MAG_W + 2 * FRAC_BITS;
  localparam int ROOT_W    = RAD_W / 2;
  localparam int REM_W     = ROOT_W + 2;
  localparam int NB_W      = COEF_W + 1 + FRAC_BITS;
  localparam int NUM_W     = ROOT_W + 1;
  localparam int DEN_W     = COEF_W + 1;
  localparam int DREM_W    = DEN_W + 1;
  localparam int VAL_W     = 41;
  localparam int CLIP_W    = (NUM_W + 1 > VAL_W) ? NUM_W + 2 : VAL_W + 1;
  localparam int IN_W      = 3 * COEF_W;
  localparam int OUT_W     = 88;

  localparam logic signed [VAL_W-1:0] VAL_MAX = {1'b0, {(VAL_W-1){1'b1}}};
  localparam logic signed [VAL_W-1:0] VAL_MIN = {1'b1, {(VAL_W-1){1'b0}}};

  typedef enum logic [1:0] {
    KIND_NONE,
    KIND_SINGLE,
    KIND_TWO,
    KIND_COMPLEX
  } qrs_kind_t;

  // sideband carried through the root pipeline
  typedef struct packed {
    qrs_kind_t               kind;
    logic signed [NB_W-1:0]  nb;
    logic                    den_neg;
    logic [DEN_W-1:0]        den_mag;
  } qrs_side_t;

  // sideband carried through the divider
  typedef struct packed {
    qrs_kind_t kind;
    logic      neg1;
    logic      neg2;
  } qrs_dtag_t;

  // apply sign to a quotient magnitude and clip, returns {clipped, value}
  function automatic logic [VAL_W:0] clip_val(input logic neg, input logic [NUM_W-1:0] mag);
    logic signed [CLIP_W-1:0] v;
    logic signed [CLIP_W-1:0] hi;
    logic signed [CLIP_W-1:0] lo;
    logic [VAL_W:0]           res;
    v  = signed'(CLIP_W'(mag));
    if (neg) begin
      v = -v;
    end
    hi = CLIP_W'(VAL_MAX);
    lo = CLIP_W'(VAL_MIN);
    if (v > hi) begin
      res = {1'b1, VAL_MAX};
    end else if (v < lo) begin
      res = {1'b1, VAL_MIN};
    end else begin
      res = {1'b0, v[VAL_W-1:0]};
    end
    return res;
  endfunction

endpackage

// ===== rtl/core/quadratic_root_solver.sv =====
// throughput: one beat per cycle while the output is not stalled; the root unit and divider take one bit per stage
// the whole pipeline advances whenever the output register is empty or taken
// reset (synchronous, active low) clears all stage valid bits and the output valid
// payload registers are not reset
module quadratic_root_solver (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_tvalid,
  output logic                       in_tready,
  input  logic [qrs_pkg::IN_W-1:0]   in_tdata,   // coef_square, coef_linear, coef_const
  output logic                       out_tvalid,
  input  logic                       out_tready,
  output logic [qrs_pkg::OUT_W-1:0]  out_tdata,  // first_value, second_value, saturated, zero pad
  output logic [1:0]                 out_tuser   // root_kind
);

  localparam int CW = qrs_pkg::COEF_W;

  logic en;

  // stage 1: products
  logic                               s1_vld_r;
  logic signed [CW-1:0]               s1_a_r;
  logic signed [CW-1:0]               s1_b_r;
  logic signed [qrs_pkg::PROD_W-1:0]  s1_bb_r;
  logic signed [qrs_pkg::PROD_W-1:0]  s1_ac_r;
  logic signed [CW-1:0]               a_in;
  logic signed [CW-1:0]               b_in;
  logic signed [CW-1:0]               c_in;

  // stage 2: discriminant and side values
  logic                               s2_vld_r;
  logic [qrs_pkg::MAG_W-1:0]          s2_mag_r;
  qrs_pkg::qrs_side_t                 s2_side_r;
  logic signed [qrs_pkg::DISC_W-1:0]  disc;
  logic [qrs_pkg::DISC_W-1:0]         disc_abs;
  logic signed [CW:0]                 a_ext;
  logic [CW:0]                        a_abs;
  qrs_pkg::qrs_side_t                 side_nxt;

  // root unit output
  logic                               sq_vld;
  logic [qrs_pkg::ROOT_W-1:0]         sq_root;
  qrs_pkg::qrs_side_t                 sq_side;

  // stage 3: numerators
  logic                               s3_vld_r;
  logic [qrs_pkg::NUM_W-1:0]          s3_num1_r;
  logic [qrs_pkg::NUM_W-1:0]          s3_num2_r;
  logic [qrs_pkg::DEN_W-1:0]          s3_den_r;
  qrs_pkg::qrs_dtag_t                 s3_tag_r;
  logic signed [qrs_pkg::NUM_W:0]     nb_w;
  logic signed [qrs_pkg::NUM_W:0]     rt_w;
  logic signed [qrs_pkg::NUM_W:0]     n1;
  logic signed [qrs_pkg::NUM_W:0]     n2;
  logic [qrs_pkg::NUM_W:0]            n1_abs;
  logic [qrs_pkg::NUM_W:0]            n2_abs;
  qrs_pkg::qrs_dtag_t                 tag_nxt;

  // divider output
  logic                               dv_vld;
  logic [qrs_pkg::NUM_W-1:0]          dv_q1;
  logic [qrs_pkg::NUM_W-1:0]          dv_q2;
  qrs_pkg::qrs_dtag_t                 dv_tag;

  // output register
  logic                               out_vld_r;
  qrs_pkg::qrs_kind_t                 kind_r;
  logic [qrs_pkg::VAL_W-1:0]          first_r;
  logic [qrs_pkg::VAL_W-1:0]          second_r;
  logic                               sat_r;
  logic [qrs_pkg::VAL_W:0]            c1;
  logic [qrs_pkg::VAL_W:0]            c2;
  logic [qrs_pkg::VAL_W-1:0]          first_nxt;
  logic [qrs_pkg::VAL_W-1:0]          second_nxt;
  logic                               sat_nxt;

  // pipeline moves when the output slot is free or being taken
  assign en        = !out_vld_r || out_tready;
  assign in_tready = en;

  assign a_in = in_tdata[CW-1:0];
  assign b_in = in_tdata[2*CW-1:CW];
  assign c_in = in_tdata[3*CW-1:2*CW];

  // stage 1 registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else if (en) begin
      s1_vld_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_a_r  <= a_in;
      s1_b_r  <= b_in;
      s1_bb_r <= b_in * b_in;
      s1_ac_r <= a_in * c_in;
    end
  end

  // discriminant, kind, -b scaled and |2a|
  always_comb begin
    disc     = qrs_pkg::DISC_W'(s1_bb_r) - (qrs_pkg::DISC_W'(s1_ac_r) <<< 2);
    disc_abs = disc[qrs_pkg::DISC_W-1] ? qrs_pkg::DISC_W'(-disc) : qrs_pkg::DISC_W'(disc);
    a_ext    = (CW+1)'(s1_a_r);
    a_abs    = a_ext[CW] ? (CW+1)'(-a_ext) : (CW+1)'(a_ext);
    if (s1_a_r == '0) begin
      side_nxt.kind = qrs_pkg::KIND_NONE;
    end else if (disc == '0) begin
      side_nxt.kind = qrs_pkg::KIND_SINGLE;
    end else if (!disc[qrs_pkg::DISC_W-1]) begin
      side_nxt.kind = qrs_pkg::KIND_TWO;
    end else begin
      side_nxt.kind = qrs_pkg::KIND_COMPLEX;
    end
    side_nxt.nb      = -(qrs_pkg::NB_W'(s1_b_r) <<< qrs_pkg::FRAC_BITS);
    side_nxt.den_neg = s1_a_r[CW-1];
    side_nxt.den_mag = {a_abs[CW-1:0], 1'b0};
  end

  // stage 2 registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_vld_r <= 1'b0;
    end else if (en) begin
      s2_vld_r <= s1_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s2_mag_r  <= disc_abs[qrs_pkg::MAG_W-1:0];
      s2_side_r <= side_nxt;
    end
  end

  qrs_sqrt u_sqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_vld   (s2_vld_r),
    .in_mag   (s2_mag_r),
    .in_side  (s2_side_r),
    .out_vld  (sq_vld),
    .out_root (sq_root),
    .out_side (sq_side)
  );

  // numerators as sign and magnitude
  always_comb begin
    nb_w = (qrs_pkg::NUM_W+1)'(sq_side.nb);
    rt_w = signed'((qrs_pkg::NUM_W+1)'(sq_root));
    if (sq_side.kind == qrs_pkg::KIND_TWO) begin
      n1 = nb_w + rt_w;
      n2 = nb_w - rt_w;
    end else begin
      n1 = nb_w;
      n2 = rt_w;
    end
    n1_abs       = n1[qrs_pkg::NUM_W] ? (qrs_pkg::NUM_W+1)'(-n1) : (qrs_pkg::NUM_W+1)'(n1);
    n2_abs       = n2[qrs_pkg::NUM_W] ? (qrs_pkg::NUM_W+1)'(-n2) : (qrs_pkg::NUM_W+1)'(n2);
    tag_nxt.kind = sq_side.kind;
    tag_nxt.neg1 = n1[qrs_pkg::NUM_W] ^ sq_side.den_neg;
    tag_nxt.neg2 = (sq_side.kind == qrs_pkg::KIND_TWO) ?
                   (n2[qrs_pkg::NUM_W] ^ sq_side.den_neg) : 1'b0;
  end

  // stage 3 registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_vld_r <= 1'b0;
    end else if (en) begin
      s3_vld_r <= sq_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s3_num1_r <= n1_abs[qrs_pkg::NUM_W-1:0];
      s3_num2_r <= n2_abs[qrs_pkg::NUM_W-1:0];
      s3_den_r  <= sq_side.den_mag;
      s3_tag_r  <= tag_nxt;
    end
  end

  qrs_div u_div (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (en),
    .in_vld  (s3_vld_r),
    .in_num1 (s3_num1_r),
    .in_num2 (s3_num2_r),
    .in_den  (s3_den_r),
    .in_tag  (s3_tag_r),
    .out_vld (dv_vld),
    .out_q1  (dv_q1),
    .out_q2  (dv_q2),
    .out_tag (dv_tag)
  );

  // sign, clip and select per kind
  always_comb begin
    c1 = qrs_pkg::clip_val(dv_tag.neg1, dv_q1);
    c2 = qrs_pkg::clip_val(dv_tag.neg2, dv_q2);
    case (dv_tag.kind)
      qrs_pkg::KIND_NONE: begin
        first_nxt  = '0;
        second_nxt = '0;
        sat_nxt    = 1'b0;
      end
      qrs_pkg::KIND_SINGLE: begin
        first_nxt  = c1[qrs_pkg::VAL_W-1:0];
        second_nxt = '0;
        sat_nxt    = c1[qrs_pkg::VAL_W];
      end
      default: begin
        first_nxt  = c1[qrs_pkg::VAL_W-1:0];
        second_nxt = c2[qrs_pkg::VAL_W-1:0];
        sat_nxt    = c1[qrs_pkg::VAL_W] | c2[qrs_pkg::VAL_W];
      end
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (en) begin
      out_vld_r <= dv_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      kind_r   <= dv_tag.kind;
      first_r  <= first_nxt;
      second_r <= second_nxt;
      sat_r    <= sat_nxt;
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tuser  = kind_r;
  assign out_tdata  = {{(qrs_pkg::OUT_W-2*qrs_pkg::VAL_W-1){1'b0}}, sat_r, second_r, first_r};

  // not quadratic gives all-zero values
  a_none_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser == qrs_pkg::KIND_NONE) |-> (out_tdata == '0))
    else $error("not quadratic beat carries nonzero values");

  // single root has zero second value
  a_single_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser == qrs_pkg::KIND_SINGLE) |->
    (out_tdata[2*qrs_pkg::VAL_W-1:qrs_pkg::VAL_W] == '0))
    else $error("single root beat has nonzero second value");

  // imaginary magnitude is never negative
  a_imag_pos: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser == qrs_pkg::KIND_COMPLEX) |-> !out_tdata[2*qrs_pkg::VAL_W-1])
    else $error("negative imaginary magnitude");

  // input side ready follows the output slot
  a_ready: assert property (@(posedge clk) disable iff (!rst_n)
    in_tready == (!out_tvalid || out_tready))
    else $error("input ready does not follow output slot");

endmodule

// ===== rtl/core/qrs_sqrt.sv =====
// pipelined integer square root of |D| * 2^(2*FRAC_BITS), one root bit per stage
module qrs_sqrt (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           en,
  input  logic                           in_vld,
  input  logic [qrs_pkg::MAG_W-1:0]      in_mag,
  input  qrs_pkg::qrs_side_t             in_side,
  output logic                           out_vld,
  output logic [qrs_pkg::ROOT_W-1:0]     out_root,
  output qrs_pkg::qrs_side_t             out_side
);

  localparam int N = qrs_pkg::ROOT_W;

  logic [qrs_pkg::REM_W-1:0]  rem_r  [N];
  logic [N-1:0]               root_r [N];
  logic [qrs_pkg::MAG_W-1:0]  mag_r  [N];
  qrs_pkg::qrs_side_t         side_r [N];
  logic [N-1:0]               vld_r;

  for (genvar s = 0; s < N; s++) begin : g_stage
    localparam int P = N - 1 - s;
    logic [qrs_pkg::REM_W-1:0] rem_p;
    logic [N-1:0]              root_p;
    logic [qrs_pkg::MAG_W-1:0] mag_p;
    qrs_pkg::qrs_side_t        side_p;
    logic                      vld_p;
    logic [1:0]                pair;
    logic [qrs_pkg::REM_W-1:0] sh;
    logic [qrs_pkg::REM_W-1:0] trial;
    logic                      ge;

    // previous stage or pipeline input
    if (s == 0) begin : g_first
      assign rem_p  = '0;
      assign root_p = '0;
      assign mag_p  = in_mag;
      assign side_p = in_side;
      assign vld_p  = in_vld;
    end else begin : g_next
      assign rem_p  = rem_r[s-1];
      assign root_p = root_r[s-1];
      assign mag_p  = mag_r[s-1];
      assign side_p = side_r[s-1];
      assign vld_p  = vld_r[s-1];
    end

    // next radicand bit pair, low pairs are the zero fraction
    if (P >= qrs_pkg::FRAC_BITS) begin : g_pair
      assign pair = mag_p[2*P-2*qrs_pkg::FRAC_BITS +: 2];
    end else begin : g_zero
      assign pair = 2'b00;
    end

    // one restoring root step
    always_comb begin
      sh    = {rem_p[qrs_pkg::REM_W-3:0], pair};
      trial = {root_p, 2'b01};
      ge    = (sh >= trial);
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[s] <= 1'b0;
      end else if (en) begin
        vld_r[s] <= vld_p;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[s]  <= ge ? (sh - trial) : sh;
        root_r[s] <= {root_p[N-2:0], ge};
        mag_r[s]  <= mag_p;
        side_r[s] <= side_p;
      end
    end
  end

  assign out_vld  = vld_r[N-1];
  assign out_root = root_r[N-1];
  assign out_side = side_r[N-1];

endmodule

// ===== rtl/core/qrs_div.sv =====
// pipelined two-lane restoring divider by a shared denominator, one quotient bit per stage
module qrs_div (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          en,
  input  logic                          in_vld,
  input  logic [qrs_pkg::NUM_W-1:0]     in_num1,
  input  logic [qrs_pkg::NUM_W-1:0]     in_num2,
  input  logic [qrs_pkg::DEN_W-1:0]     in_den,
  input  qrs_pkg::qrs_dtag_t            in_tag,
  output logic                          out_vld,
  output logic [qrs_pkg::NUM_W-1:0]     out_q1,
  output logic [qrs_pkg::NUM_W-1:0]     out_q2,
  output qrs_pkg::qrs_dtag_t            out_tag
);

  localparam int N = qrs_pkg::NUM_W;
  localparam int R = qrs_pkg::DREM_W;

  logic [R-1:0]                   rem1_r [N];
  logic [R-1:0]                   rem2_r [N];
  logic [N-1:0]                   num1_r [N];
  logic [N-1:0]                   num2_r [N];
  logic [qrs_pkg::DEN_W-1:0]      den_r  [N];
  qrs_pkg::qrs_dtag_t             tag_r  [N];
  logic [N-1:0]                   vld_r;

  for (genvar s = 0; s < N; s++) begin : g_stage
    logic [R-1:0]              rem1_p;
    logic [R-1:0]              rem2_p;
    logic [N-1:0]              num1_p;
    logic [N-1:0]              num2_p;
    logic [qrs_pkg::DEN_W-1:0] den_p;
    qrs_pkg::qrs_dtag_t        tag_p;
    logic                      vld_p;
    logic [R-1:0]              sh1;
    logic [R-1:0]              sh2;
    logic [R-1:0]              dd;
    logic                      ge1;
    logic                      ge2;

    // previous stage or pipeline input
    if (s == 0) begin : g_first
      assign rem1_p = '0;
      assign rem2_p = '0;
      assign num1_p = in_num1;
      assign num2_p = in_num2;
      assign den_p  = in_den;
      assign tag_p  = in_tag;
      assign vld_p  = in_vld;
    end else begin : g_next
      assign rem1_p = rem1_r[s-1];
      assign rem2_p = rem2_r[s-1];
      assign num1_p = num1_r[s-1];
      assign num2_p = num2_r[s-1];
      assign den_p  = den_r[s-1];
      assign tag_p  = tag_r[s-1];
      assign vld_p  = vld_r[s-1];
    end

    // shift in next numerator bit and trial subtract
    always_comb begin
      dd  = R'(den_p);
      sh1 = {rem1_p[R-2:0], num1_p[N-1]};
      sh2 = {rem2_p[R-2:0], num2_p[N-1]};
      ge1 = (sh1 >= dd);
      ge2 = (sh2 >= dd);
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[s] <= 1'b0;
      end else if (en) begin
        vld_r[s] <= vld_p;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem1_r[s] <= ge1 ? (sh1 - dd) : sh1;
        rem2_r[s] <= ge2 ? (sh2 - dd) : sh2;
        num1_r[s] <= {num1_p[N-2:0], ge1};
        num2_r[s] <= {num2_p[N-2:0], ge2};
        den_r[s]  <= den_p;
        tag_r[s]  <= tag_p;
      end
    end
  end

  assign out_vld = vld_r[N-1];
  assign out_q1  = num1_r[N-1];
  assign out_q2  = num2_r[N-1];
  assign out_tag = tag_r[N-1];

endmodule

// ===== dv/tb.sv =====
// testbench of the quadratic root solver: a root predictor and scoreboard around directed and random beats
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    qrs_pkg::qrs_kind_t               kind;
    logic signed [qrs_pkg::VAL_W-1:0] v1;
    logic signed [qrs_pkg::VAL_W-1:0] v2;
    logic                             sat;
  } roots_t;

  // root predictor and store of expected roots
  class root_board;
    roots_t pending[$];
    int     errors;

    function logic signed [qrs_pkg::VAL_W-1:0] clip41(longint v, inout logic sat);
      longint hi;
      longint lo;
      hi = (longint'(1) <<< (qrs_pkg::VAL_W - 1)) - 1;
      lo = -hi - 1;
      if (v > hi) begin
        sat = 1'b1;
        return qrs_pkg::VAL_MAX;
      end
      if (v < lo) begin
        sat = 1'b1;
        return qrs_pkg::VAL_MIN;
      end
      return v[qrs_pkg::VAL_W-1:0];
    endfunction

    // floor(sqrt(mag * 2^(2*FRAC_BITS)))
    function longint scaled_root(longint mag);
      logic [127:0] rad;
      logic [127:0] t;
      logic [127:0] r;
      rad = 128'(mag) << (2 * qrs_pkg::FRAC_BITS);
      r = '0;
      for (int i = 45; i >= 0; i--) begin
        t = r | (128'd1 << i);
        if (t * t <= rad) begin
          r = t;
        end
      end
      return longint'(r);
    endfunction

    function void note_coefs(shortint a, shortint b, shortint c);
      roots_t e;
      longint disc;
      longint nb;
      longint den;
      longint rt;
      e.sat = 1'b0;
      e.v1 = '0;
      e.v2 = '0;
      if (a == 0) begin
        e.kind = qrs_pkg::KIND_NONE;
      end else begin
        disc = longint'(b) * b - 4 * longint'(a) * c;
        nb = -longint'(b) * (longint'(1) <<< qrs_pkg::FRAC_BITS);
        den = 2 * longint'(a);
        if (disc == 0) begin
          e.kind = qrs_pkg::KIND_SINGLE;
          e.v1 = clip41(nb / den, e.sat);
        end else if (disc > 0) begin
          e.kind = qrs_pkg::KIND_TWO;
          rt = scaled_root(disc);
          e.v1 = clip41((nb + rt) / den, e.sat);
          e.v2 = clip41((nb - rt) / den, e.sat);
        end else begin
          e.kind = qrs_pkg::KIND_COMPLEX;
          rt = scaled_root(-disc);
          e.v1 = clip41(nb / den, e.sat);
          e.v2 = clip41(rt / (den < 0 ? -den : den), e.sat);
        end
      end
      pending.push_back(e);
    endfunction

    task report(string what, longint got, longint want);
      $display("mismatch on %s: got %0d, expected %0d", what, got, want);
      errors++;
    endtask

    task check_roots(qrs_pkg::qrs_kind_t kind, logic signed [qrs_pkg::VAL_W-1:0] v1,
                     logic signed [qrs_pkg::VAL_W-1:0] v2, logic sat);
      roots_t e;
      if (pending.size() == 0) begin
        report("unexpected beat", 1, 0);
        return;
      end
      e = pending.pop_front();
      if (kind != e.kind) report("root_kind", kind, e.kind);
      if (v1 != e.v1) report("first_value", v1, e.v1);
      if (v2 != e.v2) report("second_value", v2, e.v2);
      if (sat != e.sat) report("saturated", sat, e.sat);
    endtask
  endclass

  logic                       clk = 1'b0;
  logic                       rst_n = 1'b0;
  logic                       in_tvalid = 1'b0;
  logic                       in_tready;
  logic [qrs_pkg::IN_W-1:0]   in_tdata = '0;
  logic                       out_tvalid;
  logic                       out_tready = 1'b0;
  logic [qrs_pkg::OUT_W-1:0]  out_tdata;
  logic [1:0]                 out_tuser;

  root_board board = new();
  bit        idle_on = 1'b1;

  always #1 clk = ~clk;

  quadratic_root_solver i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  // note accepted coefficients and check accepted roots
  always @(posedge clk) begin
    if (rst_n && in_tvalid && in_tready) begin
      board.note_coefs(in_tdata[15:0], in_tdata[31:16], in_tdata[47:32]);
    end
    if (rst_n && out_tvalid && out_tready) begin
      board.check_roots(qrs_pkg::qrs_kind_t'(out_tuser), out_tdata[40:0], out_tdata[81:41],
                        out_tdata[82]);
    end
  end

  // receiver stalls in bursts
  initial begin
    int n;
    forever begin
      @(negedge clk);
      if (idle_on && $urandom_range(0, 9) == 0) begin
        n = $urandom_range(1, 17);
        out_tready <= 1'b0;
        repeat (n) @(negedge clk);
      end
      out_tready <= 1'b1;
    end
  end

  // one coefficient beat, called at a falling edge
  task send_coefs(shortint a, shortint b, shortint c);
    int n;
    if (idle_on && $urandom_range(0, 9) == 0) begin
      n = $urandom_range(1, 17);
      in_tvalid <= 1'b0;
      repeat (n) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= {c, b, a};
    do @(posedge clk); while (!in_tready);
    @(negedge clk);
  endtask

  task settle();
    in_tvalid <= 1'b0;
    while (board.pending.size() != 0) @(negedge clk);
  endtask

  // random coefficient set, mostly shaped toward each kind of roots
  task send_random();
    shortint m;
    shortint k;
    case ($urandom_range(0, 5))
      0, 1: send_coefs(shortint'($urandom), shortint'($urandom), shortint'($urandom));
      2: begin
        // perfect square: single root, or not quadratic when m is zero
        m = shortint'($urandom_range(0, 360) - 180);
        k = shortint'($urandom_range(0, 18) - 9);
        send_coefs(m, shortint'(2 * m * k), shortint'(m * k * k));
      end
      3: send_coefs(shortint'($urandom_range(0, 64) - 32), shortint'($urandom),
                    shortint'($urandom_range(0, 64) - 32));
      4: send_coefs(shortint'($urandom_range(0, 16) - 8), shortint'($urandom_range(0, 16) - 8),
                    shortint'($urandom_range(0, 16) - 8));
      default: send_coefs(($urandom_range(0, 10) == 0) ? shortint'(0) : shortint'($urandom),
                          shortint'($urandom), shortint'($urandom));
    endcase
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed: not quadratic, extremes, each kind of roots
    send_coefs(0, 0, 0);
    send_coefs(0, 32767, -32768);
    send_coefs(1, 2, 1);
    send_coefs(-1, 2, -1);
    send_coefs(4, -4, 1);
    send_coefs(1, 0, -1);
    send_coefs(1, -3, 2);
    send_coefs(1, 0, 1);
    send_coefs(1, 1, 1);
    send_coefs(-32768, -32768, -32768);
    send_coefs(32767, 32767, 32767);
    send_coefs(-32768, 32767, 32767);
    send_coefs(32767, -32768, -32768);
    send_coefs(1, -32768, -32768);
    send_coefs(1, 32767, 0);
    send_coefs(-1, -32768, 32767);
    send_coefs(32767, 1, 0);
    send_coefs(-32768, 0, 1);
    send_coefs(3, 7, -11);
    send_coefs(-5, 1, -9);
    settle();

    for (int i = 0; i < 1300; i++) begin
      if (i == 1100) idle_on = 1'b0;
      send_random();
    end
    in_tvalid <= 1'b0;
    while (board.pending.size() != 0) @(negedge clk);
    repeat (100) @(negedge clk);
    if (board.errors == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("FAILED: results differ");
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/core/qrs_pkg.sv
rtl/core/qrs_sqrt.sv
rtl/core/qrs_div.sv
rtl/core/quadratic_root_solver.sv
dv/tb.sv
